### rtl/core/tpsbl_pkg.sv
// Shared types and constants for the tree path-sum / LCA engine.
// No dependencies; every other file in rtl/core but tpsbl_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package tpsbl_pkg;

  localparam int ID_W     = 10;
  localparam int OP_W     = 2;
  localparam int WEIGHT_W = 32;
  localparam int TOTAL_W  = 48;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  typedef struct packed {
    logic               status;
    logic [ID_W-1:0]    meet;
    logic [TOTAL_W-1:0] total;
  } res_t;

  localparam res_t RES_OK  = '{status: ST_OK,  meet: '0, total: '0};
  localparam res_t RES_ERR = '{status: ST_ERR, meet: '0, total: '0};

endpackage

`default_nettype wire

### rtl/core/tpsbl_ram.sv
// Synchronous RAM: one write port and two read ports, read data registered.
// Stand-alone; used for the node table and the ancestor table.
`timescale 1ns / 1ps
`default_nettype none

module tpsbl_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [WIDTH-1:0]  rdata_a,
  output logic      [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

### rtl/core/tpsbl_seq.sv
// Sequencer for load, query and clear transactions over the node and ancestor RAMs.
// Depends on tpsbl_pkg and tpsbl_ram.
`timescale 1ns / 1ps
`default_nettype none

module tpsbl_seq #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [tpsbl_pkg::OP_W-1:0]           in_op,
  input  wire logic [tpsbl_pkg::ID_W-1:0]           in_node_id,
  input  wire logic [tpsbl_pkg::ID_W-1:0]           in_parent_or_peer,
  input  wire logic [tpsbl_pkg::WEIGHT_W-1:0]       in_edge_weight,
  output logic                                      res_valid,
  output tpsbl_pkg::res_t                           res,
  input  wire logic                                 res_take
);

  localparam int IDX_W  = $clog2(NODES);
  localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVW    = IDX_W;
  localparam int PRE_W  = tpsbl_pkg::TOTAL_W;
  localparam int NODE_W = 1 + LVW + PRE_W;
  localparam int ANC_AW = LW + IDX_W;
  localparam logic [LW-1:0]    LAST_LVL = LW'(LEVELS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES - 1);

  typedef enum logic [12:0] {
    S_CLR     = 13'b0000000000001,
    S_IDLE    = 13'b0000000000010,
    S_LD_N    = 13'b0000000000100,
    S_LD_ROOT = 13'b0000000001000,
    S_LD_ANC  = 13'b0000000010000,
    S_Q_N     = 13'b0000000100000,
    S_LIFT    = 13'b0000001000000,
    S_LIFT_W  = 13'b0000010000000,
    S_LCHK    = 13'b0000100000000,
    S_JUMP    = 13'b0001000000000,
    S_FINAL   = 13'b0010000000000,
    S_SUM     = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t                            state_r, state_nxt;
  logic [tpsbl_pkg::ID_W-1:0]        u_r, u_nxt;
  logic [tpsbl_pkg::ID_W-1:0]        p_r, p_nxt;
  logic [tpsbl_pkg::WEIGHT_W-1:0]    w_r, w_nxt;
  logic [IDX_W-1:0]                  a_r, a_nxt;
  logic [IDX_W-1:0]                  b_r, b_nxt;
  logic [IDX_W-1:0]                  meet_r, meet_nxt;
  logic [IDX_W-1:0]                  clr_cnt_r, clr_cnt_nxt;
  logic                              clr_op_r, clr_op_nxt;
  logic [LW-1:0]                     lvl_r, lvl_nxt;
  logic [LVW-1:0]                    diff_r, diff_nxt;
  logic [PRE_W-1:0]                  sum_uv_r, sum_uv_nxt;
  tpsbl_pkg::res_t                   res_r, res_nxt;

  // RAM ports
  logic                node_we;
  logic [IDX_W-1:0]    node_waddr, node_ra, node_rb;
  logic [NODE_W-1:0]   node_wdata, node_rd_a, node_rd_b;
  logic                anc_we;
  logic [ANC_AW-1:0]   anc_waddr, anc_ra, anc_rb;
  logic [IDX_W-1:0]    anc_wdata, anc_rd_a, anc_rd_b;

  tpsbl_ram #(.WIDTH(NODE_W), .ADDR_W(IDX_W)) u_node_ram (
    .clk     (clk),
    .we      (node_we),
    .waddr   (node_waddr),
    .wdata   (node_wdata),
    .raddr_a (node_ra),
    .raddr_b (node_rb),
    .rdata_a (node_rd_a),
    .rdata_b (node_rd_b)
  );

  tpsbl_ram #(.WIDTH(IDX_W), .ADDR_W(ANC_AW)) u_anc_ram (
    .clk     (clk),
    .we      (anc_we),
    .waddr   (anc_waddr),
    .wdata   (anc_wdata),
    .raddr_a (anc_ra),
    .raddr_b (anc_rb),
    .rdata_a (anc_rd_a),
    .rdata_b (anc_rd_b)
  );

  // Node numbers widened to 32 bits, then cut to the table index width.
  logic [31:0]       in_u_ext, in_p_ext, u_ext, p_ext, meet_ext;
  logic [IDX_W-1:0]  in_u_idx, in_p_idx, u_idx, p_idx;
  logic              in_u_ok, in_p_ok, p_ok;

  assign in_u_ext = 32'(in_node_id);
  assign in_p_ext = 32'(in_parent_or_peer);
  assign u_ext    = 32'(u_r);
  assign p_ext    = 32'(p_r);
  assign meet_ext = 32'(meet_r);
  assign in_u_idx = in_u_ext[IDX_W-1:0];
  assign in_p_idx = in_p_ext[IDX_W-1:0];
  assign u_idx    = u_ext[IDX_W-1:0];
  assign p_idx    = p_ext[IDX_W-1:0];
  assign in_u_ok  = in_u_ext < 32'(NODES);
  assign in_p_ok  = in_p_ext < 32'(NODES);
  assign p_ok     = p_ext < 32'(NODES);

  // Node entry: {present, level, prefix}
  logic             pres_a, pres_b;
  logic [LVW-1:0]   lvl_a, lvl_b;
  logic [PRE_W-1:0] pre_a, pre_b;
  logic [PRE_W-1:0] w_sext;
  logic [31:0]      step32;
  logic [LVW-1:0]   step;
  logic             lift_now;
  logic [IDX_W-1:0] jump_a, jump_b;

  assign pres_a   = node_rd_a[NODE_W-1];
  assign pres_b   = node_rd_b[NODE_W-1];
  assign lvl_a    = node_rd_a[PRE_W +: LVW];
  assign lvl_b    = node_rd_b[PRE_W +: LVW];
  assign pre_a    = node_rd_a[PRE_W-1:0];
  assign pre_b    = node_rd_b[PRE_W-1:0];
  assign w_sext   = {{(PRE_W - tpsbl_pkg::WEIGHT_W){w_r[tpsbl_pkg::WEIGHT_W-1]}}, w_r};
  assign step32   = 32'd1 << lvl_r;
  assign step     = LVW'(step32);
  assign lift_now = 32'(diff_r) >= step32;
  // Advance both nodes only while their ancestors differ.
  assign jump_a   = (anc_rd_a != anc_rd_b) ? anc_rd_a : a_r;
  assign jump_b   = (anc_rd_a != anc_rd_b) ? anc_rd_b : b_r;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_comb begin
    state_nxt   = state_r;
    u_nxt       = u_r;
    p_nxt       = p_r;
    w_nxt       = w_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    meet_nxt    = meet_r;
    clr_cnt_nxt = clr_cnt_r;
    clr_op_nxt  = clr_op_r;
    lvl_nxt     = lvl_r;
    diff_nxt    = diff_r;
    sum_uv_nxt  = sum_uv_r;
    res_nxt     = res_r;
    node_we     = 1'b0;
    node_waddr  = u_idx;
    node_wdata  = '0;
    node_ra     = '0;
    node_rb     = '0;
    anc_we      = 1'b0;
    anc_waddr   = {lvl_r, u_idx};
    anc_wdata   = u_idx;
    anc_ra      = '0;
    anc_rb      = '0;

    unique case (state_r)
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_cnt_r;
        if (clr_cnt_r == LAST_IDX) begin
          if (clr_op_r) begin
            res_nxt   = tpsbl_pkg::RES_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_cnt_nxt = clr_cnt_r + IDX_W'(1);
        end
      end

      S_IDLE: begin
        node_ra = in_u_idx;
        node_rb = in_p_idx;
        if (in_valid) begin
          u_nxt = in_node_id;
          p_nxt = in_parent_or_peer;
          w_nxt = in_edge_weight;
          unique case (in_op)
            tpsbl_pkg::OP_LOAD: begin
              if (in_u_ok) begin
                state_nxt = S_LD_N;
              end else begin
                res_nxt   = tpsbl_pkg::RES_ERR;
                state_nxt = S_DONE;
              end
            end
            tpsbl_pkg::OP_QUERY: begin
              if (in_u_ok && in_p_ok) begin
                state_nxt = S_Q_N;
              end else begin
                res_nxt   = tpsbl_pkg::RES_ERR;
                state_nxt = S_DONE;
              end
            end
            tpsbl_pkg::OP_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_op_nxt  = 1'b1;
              state_nxt   = S_CLR;
            end
            default: begin
              res_nxt   = tpsbl_pkg::RES_ERR;
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_LD_N: begin
        priority if (pres_a) begin
          res_nxt   = tpsbl_pkg::RES_ERR;
          state_nxt = S_DONE;
        end else if (u_r == p_r) begin
          // root: depth 0, prefix 0, every ancestor is itself
          node_we    = 1'b1;
          node_wdata = {1'b1, {LVW{1'b0}}, {PRE_W{1'b0}}};
          anc_we     = 1'b1;
          anc_waddr  = {LW'(0), u_idx};
          anc_wdata  = u_idx;
          lvl_nxt    = LW'(1);
          if (LEVELS == 1) begin
            res_nxt   = tpsbl_pkg::RES_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LD_ROOT;
          end
        end else if (!p_ok || !pres_b) begin
          res_nxt   = tpsbl_pkg::RES_ERR;
          state_nxt = S_DONE;
        end else begin
          node_we    = 1'b1;
          node_wdata = {1'b1, lvl_b + LVW'(1), pre_b + w_sext};
          anc_we     = 1'b1;
          anc_waddr  = {LW'(0), u_idx};
          anc_wdata  = p_idx;
          anc_ra     = {LW'(0), p_idx};
          lvl_nxt    = LW'(1);
          if (LEVELS == 1) begin
            res_nxt   = tpsbl_pkg::RES_OK;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_LD_ANC;
          end
        end
      end

      S_LD_ROOT: begin
        anc_we    = 1'b1;
        anc_waddr = {lvl_r, u_idx};
        anc_wdata = u_idx;
        if (lvl_r == LAST_LVL) begin
          res_nxt   = tpsbl_pkg::RES_OK;
          state_nxt = S_DONE;
        end else begin
          lvl_nxt = lvl_r + LW'(1);
        end
      end

      S_LD_ANC: begin
        // read data is the ancestor at this level; chain the next read through it
        anc_we    = 1'b1;
        anc_waddr = {lvl_r, u_idx};
        anc_wdata = anc_rd_a;
        anc_ra    = {lvl_r, anc_rd_a};
        if (lvl_r == LAST_LVL) begin
          res_nxt   = tpsbl_pkg::RES_OK;
          state_nxt = S_DONE;
        end else begin
          lvl_nxt = lvl_r + LW'(1);
        end
      end

      S_Q_N: begin
        if (!pres_a || !pres_b) begin
          res_nxt   = tpsbl_pkg::RES_ERR;
          state_nxt = S_DONE;
        end else begin
          sum_uv_nxt = pre_a + pre_b;
          lvl_nxt    = LAST_LVL;
          state_nxt  = S_LIFT;
          if (lvl_a < lvl_b) begin
            a_nxt    = p_idx;
            b_nxt    = u_idx;
            diff_nxt = lvl_b - lvl_a;
          end else begin
            a_nxt    = u_idx;
            b_nxt    = p_idx;
            diff_nxt = lvl_a - lvl_b;
          end
        end
      end

      S_LIFT: begin
        anc_ra = {lvl_r, a_r};
        priority if (lift_now) begin
          state_nxt = S_LIFT_W;
        end else if (lvl_r == '0) begin
          state_nxt = S_LCHK;
        end else begin
          lvl_nxt = lvl_r - LW'(1);
        end
      end

      S_LIFT_W: begin
        a_nxt    = anc_rd_a;
        diff_nxt = diff_r - step;
        if (lvl_r == '0) begin
          state_nxt = S_LCHK;
        end else begin
          lvl_nxt   = lvl_r - LW'(1);
          state_nxt = S_LIFT;
        end
      end

      S_LCHK: begin
        priority if (diff_r != '0) begin
          res_nxt   = tpsbl_pkg::RES_ERR;
          state_nxt = S_DONE;
        end else if (a_r == b_r) begin
          meet_nxt  = a_r;
          node_ra   = a_r;
          state_nxt = S_SUM;
        end else begin
          lvl_nxt   = LAST_LVL;
          anc_ra    = {LAST_LVL, a_r};
          anc_rb    = {LAST_LVL, b_r};
          state_nxt = S_JUMP;
        end
      end

      S_JUMP: begin
        a_nxt = jump_a;
        b_nxt = jump_b;
        if (lvl_r == '0) begin
          anc_ra    = {LW'(0), jump_a};
          anc_rb    = {LW'(0), jump_b};
          state_nxt = S_FINAL;
        end else begin
          lvl_nxt = lvl_r - LW'(1);
          anc_ra  = {lvl_r - LW'(1), jump_a};
          anc_rb  = {lvl_r - LW'(1), jump_b};
        end
      end

      S_FINAL: begin
        if (anc_rd_a != anc_rd_b) begin
          // parents still differ: no common ancestor
          res_nxt   = tpsbl_pkg::RES_ERR;
          state_nxt = S_DONE;
        end else begin
          meet_nxt  = anc_rd_a;
          node_ra   = anc_rd_a;
          state_nxt = S_SUM;
        end
      end

      S_SUM: begin
        res_nxt.status = tpsbl_pkg::ST_OK;
        res_nxt.meet   = meet_ext[tpsbl_pkg::ID_W-1:0];
        res_nxt.total  = sum_uv_r - {pre_a[PRE_W-2:0], 1'b0};
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_cnt_r <= '0;
      clr_op_r  <= 1'b0;
      lvl_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      clr_op_r  <= clr_op_nxt;
      lvl_r     <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r      <= u_nxt;
    p_r      <= p_nxt;
    w_r      <= w_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    meet_r   <= meet_nxt;
    diff_r   <= diff_nxt;
    sum_uv_r <= sum_uv_nxt;
    res_r    <= res_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/tree_path_sum_binary_lifting_core.sv
// Top level of the weighted-tree LCA / path-sum engine: sequencer plus result register.
// Depends on tpsbl_pkg and tpsbl_seq.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one transaction: op, node_id,
//   parent_or_peer, edge_weight. Every transaction gives exactly one result on the
//   output channel (out_valid/out_ready): status, meeting_node, path_total.
//   One transaction is in work at a time; in_ready is high only while idle.
//   Steps from accept to result in the output register:
//     load   one ancestor RAM write per level,
//     query  a lift pass over the levels, with a wait state after each lift,
//            then one dual-port ancestor read per level,
//     clear  one node RAM entry cleared per cycle,
//     unused op code or out-of-range id: straight to an error result;
//     a load or query naming a missing or already loaded node: after one node read.
//   Reset clears control state and then runs a clearing pass over the node
//   RAM; in_ready stays low until it ends.
//   The output register holds a result while out_ready is low; the next
//   transaction is accepted meanwhile, and its result waits in the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module tree_path_sum_binary_lifting_core #(
  parameter int NODES  = 1024,
  parameter int LEVELS = 10
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [tpsbl_pkg::OP_W-1:0]            in_op,
  input  wire logic [tpsbl_pkg::ID_W-1:0]            in_node_id,
  input  wire logic [tpsbl_pkg::ID_W-1:0]            in_parent_or_peer,
  input  wire logic signed [tpsbl_pkg::WEIGHT_W-1:0] in_edge_weight,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       out_status,
  output logic [tpsbl_pkg::ID_W-1:0]                 out_meeting_node,
  output logic signed [tpsbl_pkg::TOTAL_W-1:0]       out_path_total
);

  logic            res_valid;
  logic            res_take;
  tpsbl_pkg::res_t res;
  tpsbl_pkg::res_t out_r;
  logic            out_valid_r;

  tpsbl_seq #(.NODES(NODES), .LEVELS(LEVELS)) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_node_id        (in_node_id),
    .in_parent_or_peer (in_parent_or_peer),
    .in_edge_weight    (in_edge_weight),
    .res_valid         (res_valid),
    .res               (res),
    .res_take          (res_take)
  );

  // load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_meeting_node = out_r.meet;
  assign out_path_total   = out_r.total;

endmodule

`default_nettype wire

### rtl/core/tpsbl_checker.sv
// Port-level checks for tree_path_sum_binary_lifting_core, attached by bind.
// Depends on tpsbl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpsbl_checker (
  input wire logic                                  clk,
  input wire logic                                  rst_n,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic                                  out_status,
  input wire logic [tpsbl_pkg::ID_W-1:0]            out_meeting_node,
  input wire logic signed [tpsbl_pkg::TOTAL_W-1:0]  out_path_total
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_meeting_node) && $stable(out_path_total))
    else $error("result changed while stalled");

  // reset empties the output and starts the clearing pass
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("ready or valid right after reset");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tpsbl_pkg::ST_ERR |->
      out_meeting_node == '0 && out_path_total == '0)
    else $error("error result carries nonzero payload");

  // one transaction in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accept");

endmodule

bind tree_path_sum_binary_lifting_core tpsbl_checker u_tpsbl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_meeting_node (out_meeting_node),
  .out_path_total   (out_path_total)
);

`default_nettype wire
